// ===== src/deq_pkg.sv =====
// shared types, codes and sizes for the double-ended queue
package deq_pkg;

    localparam int DEPTH  = 1024;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [CW-1:0] LAST_PTR = CW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // operation codes
    localparam logic [2:0] KIND_CLEAR      = 3'd0;
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [2:0] KIND_POP_BACK   = 3'd4;
    localparam logic [2:0] KIND_RELEASE    = 3'd5;

    // result codes
    localparam logic [1:0] RES_ITEM  = 2'd0;
    localparam logic [1:0] RES_COUNT = 2'd1;
    localparam logic [1:0] RES_EMPTY = 2'd2;
    localparam logic [1:0] RES_FULL  = 2'd3;

    // counter slice operations
    typedef logic [2:0] cnt_op_t;
    localparam cnt_op_t CNT_HOLD = 3'd0;
    localparam cnt_op_t CNT_INC  = 3'd1;
    localparam cnt_op_t CNT_DEC  = 3'd2;
    localparam cnt_op_t CNT_CLR  = 3'd3;
    localparam cnt_op_t CNT_LOAD = 3'd4;

    // slot of each counter inside a cell
    localparam int CTR_FRONT = 0;
    localparam int CTR_BACK  = 1;
    localparam int CTR_OCC   = 2;

    typedef struct packed {
        cnt_op_t front_op;
        cnt_op_t back_op;
        cnt_op_t occ_op;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
    } deq_cmd_t;

    typedef struct packed {
        logic [1:0]               result_kind;
        logic signed [DATA_W-1:0] data;
    } deq_rsp_t;

endpackage

// ===== src/deq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/deq_cell.sv =====
// one bit slice of the front, back and occupancy counters
module deq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::cell_ctl_t ctl,
    input  logic               load_bit,
    input  logic [2:0]         carry_in,
    output logic [2:0]         carry_out,
    output logic [2:0]         q,
    output logic [2:0]         q_next
);
    import deq_pkg::*;

    logic [2:0] q_reg;
    cnt_op_t    ops [3];

    assign ops[CTR_FRONT] = ctl.front_op;
    assign ops[CTR_BACK]  = ctl.back_op;
    assign ops[CTR_OCC]   = ctl.occ_op;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            q_next[j]    = q_reg[j];
            carry_out[j] = 1'b0;
            case (ops[j])
                CNT_INC:
                begin
                    q_next[j]    = q_reg[j] ^ carry_in[j];
                    carry_out[j] = q_reg[j] & carry_in[j];
                end
                CNT_DEC:
                begin
                    q_next[j]    = q_reg[j] ^ carry_in[j];
                    carry_out[j] = ~q_reg[j] & carry_in[j];
                end
                CNT_CLR:  q_next[j] = 1'b0;
                CNT_LOAD: q_next[j] = load_bit;
                default:  q_next[j] = q_reg[j];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== src/double_ended_queue.sv =====
// double-ended queue of 32-bit items over a ring store
//
// usage
//   command channel: a word (cmd.kind, cmd.value) is taken at a rising edge
//   with start high and busy low; busy stays low, so a word can be issued
//   every cycle
//   result channel: strobe is high for one cycle with rsp.result_kind and
//   rsp.data; the result is taken at the edge that ends that cycle and the
//   receiver has no way to hold it off
//   results: a result shows in the cycle after its command word is taken
//   (the ram read register sets this); clear, successful pushes and
//   unused kinds produce no result
//   throughput: one command word per cycle, since each word does at most
//   one ram access and one step of each counter
//   structure: a row of bit-slice cells holds the front pointer, the back
//   pointer (next free slot past the back) and the occupancy; each slice
//   hands its carry or borrow to the next one up
//   reset: pointers and occupancy go to zero and no result is pending; slot
//   contents are not cleared, only occupied slots are ever read
//   errors: pop on empty gives the empty code, push on full is dropped and
//   gives the full code, both with zero data
module double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_cmd_t cmd,
    output logic              strobe,
    output deq_pkg::deq_rsp_t rsp
);
    import deq_pkg::*;

    // counter slices
    cell_ctl_t         ctl;
    logic [2:0]        cell_q      [CW];
    logic [2:0]        cell_q_next [CW];
    logic [2:0]        cell_carry  [CW];
    logic [CW-1:0]     front_q;
    logic [CW-1:0]     back_q;
    logic [CW-1:0]     occ_q;
    logic [CW-1:0]     front_next;
    logic [CW-1:0]     back_next;

    // store access
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // pending result
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [1:0]        pend_kind_reg;
    logic [1:0]        pend_kind_next;
    logic [DATA_W-1:0] pend_data_reg;
    logic [DATA_W-1:0] pend_data_next;
    logic              pend_ram_reg;
    logic              pend_ram_next;

    logic              accept;
    logic              empty;
    logic              full;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = (occ_q == '0);
    assign full   = (occ_q == FULL_CNT);

    // row of counter cells, carry ripples from bit 0 upward
    for (genvar i = 0; i < CW; i++)
    begin : g_cell
        logic [2:0] cin;
        if (i == 0)
        begin : g_lsb
            assign cin = 3'b111;
        end
        else
        begin : g_upper
            assign cin = cell_carry[i-1];
        end

        deq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load_bit  (LAST_PTR[i]),
            .carry_in  (cin),
            .carry_out (cell_carry[i]),
            .q         (cell_q[i]),
            .q_next    (cell_q_next[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < CW; i++)
        begin
            front_q[i]    = cell_q[i][CTR_FRONT];
            back_q[i]     = cell_q[i][CTR_BACK];
            occ_q[i]      = cell_q[i][CTR_OCC];
            front_next[i] = cell_q_next[i][CTR_FRONT];
            back_next[i]  = cell_q_next[i][CTR_BACK];
        end
    end

    // push front writes the slot the front pointer moves to, push back the free slot
    assign ram_waddr = (cmd.kind == KIND_PUSH_FRONT) ? front_next[AW-1:0] : back_q[AW-1:0];
    // pop back reads the slot the back pointer moves to, pop front the current front
    assign ram_raddr = (cmd.kind == KIND_POP_BACK) ? back_next[AW-1:0] : front_q[AW-1:0];

    // command decode
    always_comb
    begin
        ctl.front_op    = CNT_HOLD;
        ctl.back_op     = CNT_HOLD;
        ctl.occ_op      = CNT_HOLD;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        pend_valid_next = 1'b0;
        pend_kind_next  = RES_ITEM;
        pend_data_next  = '0;
        pend_ram_next   = 1'b0;

        if (accept)
        begin
            unique case (cmd.kind)
                KIND_CLEAR:
                begin
                    ctl.front_op = CNT_CLR;
                    ctl.back_op  = CNT_CLR;
                    ctl.occ_op   = CNT_CLR;
                end
                KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        pend_valid_next = 1'b1;
                        pend_kind_next  = RES_FULL;
                    end
                    else
                    begin
                        // wrap from slot zero to the top slot
                        ctl.front_op = (front_q == '0) ? CNT_LOAD : CNT_DEC;
                        ctl.occ_op   = CNT_INC;
                        ram_we       = 1'b1;
                    end
                end
                KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        pend_valid_next = 1'b1;
                        pend_kind_next  = RES_FULL;
                    end
                    else
                    begin
                        ctl.back_op = (back_q == LAST_PTR) ? CNT_CLR : CNT_INC;
                        ctl.occ_op  = CNT_INC;
                        ram_we      = 1'b1;
                    end
                end
                KIND_POP_FRONT:
                begin
                    pend_valid_next = 1'b1;
                    if (empty)
                    begin
                        pend_kind_next = RES_EMPTY;
                    end
                    else
                    begin
                        ctl.front_op  = (front_q == LAST_PTR) ? CNT_CLR : CNT_INC;
                        ctl.occ_op    = CNT_DEC;
                        ram_re        = 1'b1;
                        pend_ram_next = 1'b1;
                    end
                end
                KIND_POP_BACK:
                begin
                    pend_valid_next = 1'b1;
                    if (empty)
                    begin
                        pend_kind_next = RES_EMPTY;
                    end
                    else
                    begin
                        ctl.back_op   = (back_q == '0) ? CNT_LOAD : CNT_DEC;
                        ctl.occ_op    = CNT_DEC;
                        ram_re        = 1'b1;
                        pend_ram_next = 1'b1;
                    end
                end
                KIND_RELEASE:
                begin
                    ctl.front_op    = CNT_CLR;
                    ctl.back_op     = CNT_CLR;
                    ctl.occ_op      = CNT_CLR;
                    pend_valid_next = 1'b1;
                    pend_kind_next  = RES_COUNT;
                    pend_data_next  = DATA_W'(occ_q);
                end
                default:
                begin
                    // unused kinds are ignored
                end
            endcase
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_ram_reg   <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_ram_reg   <= pend_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_data_reg <= pend_data_next;
    end

    // popped items come straight from the ram read register
    assign strobe          = pend_valid_reg;
    assign rsp.result_kind = pend_kind_reg;
    assign rsp.data        = pend_ram_reg ? ram_rdata : pend_data_reg;

endmodule

// ===== src/deq_checker.sv =====
// port-level checks for the double-ended queue, bound to the top level
module deq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input deq_pkg::deq_cmd_t cmd,
    input logic              strobe,
    input deq_pkg::deq_rsp_t rsp
);
    import deq_pkg::*;

    // every result answers a word taken in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy))
        else $error("result without a command word one cycle earlier");

    // unused kinds give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind > KIND_RELEASE) |=> !strobe)
        else $error("result for an unused kind");

    // error codes carry zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (rsp.result_kind == RES_EMPTY || rsp.result_kind == RES_FULL))
            |-> (rsp.data == '0))
        else $error("error result with nonzero data");

    // a pop straight after clear finds the queue empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind == KIND_CLEAR) ##1
        (start && !busy && cmd.kind == KIND_POP_FRONT)
            |=> (strobe && rsp.result_kind == RES_EMPTY))
        else $error("pop after clear did not report empty");

    // a pop straight after a push always finds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind == KIND_PUSH_FRONT) ##1
        (start && !busy && cmd.kind == KIND_POP_FRONT)
            |=> (strobe && rsp.result_kind == RES_ITEM))
        else $error("pop after push did not return an item");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// ===== verif/tb_double_ended_queue.sv =====
// self-checking testbench for the double-ended queue: directed corners, random churn, fill to full
module tb_double_ended_queue;
    import deq_pkg::*;

    // kinds the block must ignore without a result
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    // random words per idling phase, not counting ignored kinds
    localparam int CHURN_WORDS   = 20;
    // cycles allowed for outstanding results, then quiet cycles past the last one
    localparam int DRAIN_LIMIT   = 200;
    localparam int SETTLE_CYCLES = 4;
    // mismatch lines printed before going quiet
    localparam int PRINT_LIMIT   = 20;

    // ------------------------------------------------------------------
    // scoreboard: shadow deque plus the results it owes
    // ------------------------------------------------------------------
    class deque_scoreboard;
        logic [DATA_W-1:0] slot_mem [DEPTH];
        int                front_slot;
        int                held;
        deq_rsp_t          owed [$];
        int                mismatches;
        int                words;
        int                popped;
        int                releases;
        int                empties;
        int                fulls;
        int                peak;

        function new();
            front_slot = 0;
            held       = 0;
            mismatches = 0;
            words      = 0;
            popped     = 0;
            releases   = 0;
            empties    = 0;
            fulls      = 0;
            peak       = 0;
        endfunction

        function void report(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("mismatch: %s", msg);
            mismatches++;
        endfunction

        // update the shadow deque for one accepted command word
        function void note_word(deq_cmd_t w);
            deq_rsp_t r;
            int       pos;
            r.result_kind = RES_ITEM;
            r.data        = '0;
            words++;
            case (w.kind)
                KIND_CLEAR:
                begin
                    front_slot = 0;
                    held       = 0;
                end
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (held >= DEPTH)
                    begin
                        r.result_kind = RES_FULL;
                        owed.push_back(r);
                        fulls++;
                    end
                    else if (w.kind == KIND_PUSH_FRONT)
                    begin
                        front_slot           = (front_slot + DEPTH - 1) % DEPTH;
                        slot_mem[front_slot] = w.value;
                        held++;
                    end
                    else
                    begin
                        pos           = (front_slot + held) % DEPTH;
                        slot_mem[pos] = w.value;
                        held++;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK:
                begin
                    if (held == 0)
                    begin
                        r.result_kind = RES_EMPTY;
                        empties++;
                    end
                    else if (w.kind == KIND_POP_FRONT)
                    begin
                        r.data     = slot_mem[front_slot];
                        front_slot = (front_slot + 1) % DEPTH;
                        held--;
                        popped++;
                    end
                    else
                    begin
                        pos    = (front_slot + held - 1) % DEPTH;
                        r.data = slot_mem[pos];
                        held--;
                        popped++;
                    end
                    owed.push_back(r);
                end
                KIND_RELEASE:
                begin
                    r.result_kind = RES_COUNT;
                    r.data        = held;
                    owed.push_back(r);
                    front_slot    = 0;
                    held          = 0;
                    releases++;
                end
                default:
                    ;
            endcase
            if (held > peak)
                peak = held;
        endfunction

        // compare one strobed result with the oldest owed one
        function void check_result(deq_rsp_t got);
            deq_rsp_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d data %0d",
                                 got.result_kind, got.data));
                return;
            end
            want = owed.pop_front();
            if (got.result_kind !== want.result_kind)
                report($sformatf("result_kind %0d, expected %0d",
                                 got.result_kind, want.result_kind));
            if (got.data !== want.data)
                report($sformatf("data %0d, expected %0d (result_kind %0d)",
                                 got.data, want.data, want.result_kind));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------
    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    deq_cmd_t cmd;
    logic     strobe;
    deq_rsp_t rsp;

    deque_scoreboard sb;
    int              gap_pct;

    double_ended_queue i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .rsp    (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // results cannot be held off, so every strobe is checked at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe === 1'b1)
            sb.check_result(rsp);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // issue one word; random idle cycles come first, start stays high between
    // back-to-back words so it is never dropped and raised in the same step
    task automatic send_word(input logic [2:0] k, input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= deq_cmd_t'{kind: k, value: v};
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // the word was taken at this edge
        sb.note_word(cmd);
    endtask

    // full random values half the time, otherwise the extremes, zero or all-ones
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // random mix that leans toward pushes so the queue builds up between releases
    task automatic churn(input int count);
        int         issued;
        int         roll;
        logic [2:0] k;
        issued = 0;
        while (issued < count)
        begin
            roll = $urandom_range(99);
            if (roll < 27)
                k = KIND_PUSH_FRONT;
            else if (roll < 54)
                k = KIND_PUSH_BACK;
            else if (roll < 72)
                k = KIND_POP_FRONT;
            else if (roll < 90)
                k = KIND_POP_BACK;
            else if (roll < 94)
                k = KIND_RELEASE;
            else if (roll < 97)
                k = KIND_CLEAR;
            else
                k = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
            send_word(k, pick_value());
            // ignored kinds do not count toward the mix
            if (k != KIND_SPARE_A && k != KIND_SPARE_B)
                issued++;
        end
    endtask

    // push from both ends until full, with a few pops, then work the full boundary
    task automatic fill_to_top();
        while (sb.held < DEPTH)
        begin
            if ($urandom_range(99) < 4)
                send_word($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom);
            else
                send_word($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                          pick_value());
        end
        // pushes on full are dropped and flagged
        send_word(KIND_PUSH_FRONT, $urandom);
        send_word(KIND_PUSH_BACK, $urandom);
        send_word(KIND_PUSH_FRONT, 32'h8000_0000);
        send_word(KIND_PUSH_BACK, 32'h7fff_ffff);
        // step down from full at both ends and refill
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_POP_FRONT, '0);
        send_word(KIND_PUSH_FRONT, pick_value());
        send_word(KIND_PUSH_BACK, pick_value());
        send_word(KIND_PUSH_BACK, pick_value());
        // a release of a full queue reports the largest count
        send_word(KIND_RELEASE, $urandom);
    endtask

    initial
    begin
        int phase;
        int waited;

        sb      = new();
        gap_pct = 0;
        start   = 1'b0;
        cmd     = '0;
        rst_n   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: empty pops and release, extreme values, pointer wrap
        // below slot zero, both pop ends, ignored kinds, clear versus release
        send_word(KIND_POP_FRONT, 32'h1234_5678);
        send_word(KIND_POP_BACK, '1);
        send_word(KIND_RELEASE, '0);
        send_word(KIND_PUSH_FRONT, 32'h8000_0000);
        send_word(KIND_PUSH_FRONT, 32'h7fff_ffff);
        send_word(KIND_PUSH_BACK, '0);
        send_word(KIND_PUSH_BACK, '1);
        send_word(KIND_SPARE_A, 32'h5555_5555);
        send_word(KIND_SPARE_B, 32'haaaa_aaaa);
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_POP_FRONT, '0);
        send_word(KIND_POP_FRONT, '0);
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_PUSH_BACK, 32'd1);
        send_word(KIND_PUSH_BACK, 32'd2);
        send_word(KIND_CLEAR, '1);
        send_word(KIND_POP_FRONT, '0);
        send_word(KIND_PUSH_BACK, 32'h5555_5555);
        send_word(KIND_PUSH_FRONT, 32'haaaa_aaaa);
        send_word(KIND_RELEASE, '0);
        send_word(KIND_POP_BACK, '0);

        // random part in three idling phases: light, heavy, none
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       gap_pct = 9;
                1:       gap_pct = 56;
                default: gap_pct = 0;
            endcase
            churn(CHURN_WORDS);
            if (phase == 1)
                fill_to_top();
        end
        start <= 1'b0;

        // let outstanding results arrive, then watch for strays
        waited = 0;
        while (sb.owed.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.owed.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed.size()));

        $display("covered %0d command words: %0d items popped, %0d releases, %0d empty pops,",
                 sb.words, sb.popped, sb.releases, sb.empties);
        $display("%0d full pushes, peak occupancy %0d of %0d; %0d mismatches",
                 sb.fulls, sb.peak, DEPTH, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_double_ended_queue OK");
        else
            $display("tb_double_ended_queue NOT OK");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial
    begin
        #200000;
        $display("tb_double_ended_queue NOT OK");
        $finish;
    end

endmodule
